### hdl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Opcodes, tag bytes and the single-pass encode function of the scalar encoder.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 4;

    localparam logic [OP_W-1:0] OP_SINT  = 3'd0;
    localparam logic [OP_W-1:0] OP_UINT  = 3'd1;
    localparam logic [OP_W-1:0] OP_STR   = 3'd2;
    localparam logic [OP_W-1:0] OP_BIN   = 3'd3;
    localparam logic [OP_W-1:0] OP_ARRAY = 3'd4;
    localparam logic [OP_W-1:0] OP_MAP   = 3'd5;
    localparam logic [OP_W-1:0] OP_F32   = 3'd6;
    localparam logic [OP_W-1:0] OP_F64   = 3'd7;

    localparam logic [7:0] TAG_INT8    = 8'hD0;
    localparam logic [7:0] TAG_INT16   = 8'hD1;
    localparam logic [7:0] TAG_INT32   = 8'hD2;
    localparam logic [7:0] TAG_INT64   = 8'hD3;
    localparam logic [7:0] TAG_UINT8   = 8'hCC;
    localparam logic [7:0] TAG_UINT16  = 8'hCD;
    localparam logic [7:0] TAG_UINT32  = 8'hCE;
    localparam logic [7:0] TAG_UINT64  = 8'hCF;
    localparam logic [7:0] TAG_FIXSTR  = 8'hA0;
    localparam logic [7:0] TAG_STR8    = 8'hD9;
    localparam logic [7:0] TAG_STR16   = 8'hDA;
    localparam logic [7:0] TAG_STR32   = 8'hDB;
    localparam logic [7:0] TAG_BIN8    = 8'hC4;
    localparam logic [7:0] TAG_BIN16   = 8'hC5;
    localparam logic [7:0] TAG_BIN32   = 8'hC6;
    localparam logic [7:0] TAG_FIXARR  = 8'h90;
    localparam logic [7:0] TAG_ARR16   = 8'hDC;
    localparam logic [7:0] TAG_ARR32   = 8'hDD;
    localparam logic [7:0] TAG_FIXMAP  = 8'h80;
    localparam logic [7:0] TAG_MAP16   = 8'hDE;
    localparam logic [7:0] TAG_MAP32   = 8'hDF;
    localparam logic [7:0] TAG_F32     = 8'hCA;
    localparam logic [7:0] TAG_F64     = 8'hCB;

    typedef struct packed {
        logic [BYTE_W-1:0]  tag;
        logic [VALUE_W-1:0] payload;  // left aligned, first byte in [63:56]
        logic [CNT_W-1:0]   nbytes;   // payload bytes after the tag
    } enc_t;

    function automatic enc_t msp_encode(input logic [OP_W-1:0] op,
                                        input logic [VALUE_W-1:0] v);
        enc_t             r;
        logic [31:0]      n;
        logic [BYTE_W-1:0] t;
        logic [CNT_W-1:0] nb;
        logic             s_fix;
        logic             s8;
        logic             s16;
        logic             s32;
        logic             u7;
        logic             u8;
        logic             u16;
        logic             u32;
        logic             n8;
        logic             n16;
        n     = v[31:0];
        s_fix = (v[63:7] == '0) || (&v[63:5]);
        s8    = (v[63:7] == '0) || (&v[63:7]);
        s16   = (v[63:15] == '0) || (&v[63:15]);
        s32   = (v[63:31] == '0) || (&v[63:31]);
        u7    = (v[63:7] == '0);
        u8    = (v[63:8] == '0);
        u16   = (v[63:16] == '0);
        u32   = (v[63:32] == '0);
        n8    = (n[31:8] == '0);
        n16   = (n[31:16] == '0);
        t     = TAG_F64;
        nb    = CNT_W'(8);
        unique case (op)
            OP_SINT:
            begin
                priority if (s_fix) begin t = v[7:0];   nb = CNT_W'(0); end
                else if (s8)        begin t = TAG_INT8;  nb = CNT_W'(1); end
                else if (s16)       begin t = TAG_INT16; nb = CNT_W'(2); end
                else if (s32)       begin t = TAG_INT32; nb = CNT_W'(4); end
                else                begin t = TAG_INT64; nb = CNT_W'(8); end
            end
            OP_UINT:
            begin
                priority if (u7) begin t = v[7:0];     nb = CNT_W'(0); end
                else if (u8)     begin t = TAG_UINT8;  nb = CNT_W'(1); end
                else if (u16)    begin t = TAG_UINT16; nb = CNT_W'(2); end
                else if (u32)    begin t = TAG_UINT32; nb = CNT_W'(4); end
                else             begin t = TAG_UINT64; nb = CNT_W'(8); end
            end
            OP_STR:
            begin
                priority if (n[31:5] == '0) begin t = TAG_FIXSTR | n[7:0]; nb = CNT_W'(0); end
                else if (n8)                begin t = TAG_STR8;  nb = CNT_W'(1); end
                else if (n16)               begin t = TAG_STR16; nb = CNT_W'(2); end
                else                        begin t = TAG_STR32; nb = CNT_W'(4); end
            end
            OP_BIN:
            begin
                priority if (n8) begin t = TAG_BIN8;  nb = CNT_W'(1); end
                else if (n16)    begin t = TAG_BIN16; nb = CNT_W'(2); end
                else             begin t = TAG_BIN32; nb = CNT_W'(4); end
            end
            OP_ARRAY:
            begin
                priority if (n[31:4] == '0) begin t = TAG_FIXARR | n[7:0]; nb = CNT_W'(0); end
                else if (n16)               begin t = TAG_ARR16; nb = CNT_W'(2); end
                else                        begin t = TAG_ARR32; nb = CNT_W'(4); end
            end
            OP_MAP:
            begin
                priority if (n[31:4] == '0) begin t = TAG_FIXMAP | n[7:0]; nb = CNT_W'(0); end
                else if (n16)               begin t = TAG_MAP16; nb = CNT_W'(2); end
                else                        begin t = TAG_MAP32; nb = CNT_W'(4); end
            end
            OP_F32:
            begin
                t  = TAG_F32;
                nb = CNT_W'(4);
            end
            OP_F64:
            begin
                t  = TAG_F64;
                nb = CNT_W'(8);
            end
        endcase
        r.tag    = t;
        r.nbytes = nb;
        case (nb)
            CNT_W'(0): r.payload = '0;
            CNT_W'(1): r.payload = {v[7:0], 56'd0};
            CNT_W'(2): r.payload = {v[15:0], 48'd0};
            CNT_W'(4): r.payload = {v[31:0], 32'd0};
            default:   r.payload = v;
        endcase
        return r;
    endfunction

endpackage

### hdl/msp_in_if.sv
// ----------------------------------------------------------------------------
// msp_in_if
// Input channel: opcode and 64-bit value with valid/ready.
// ----------------------------------------------------------------------------
interface msp_in_if
    import msp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

### hdl/msp_out_if.sv
// ----------------------------------------------------------------------------
// msp_out_if
// Output channel: one encoded byte per word, last byte marked.
// ----------------------------------------------------------------------------
interface msp_out_if
    import msp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

### hdl/msgpack_scalar_encoder.sv
// The tag byte passes the input register and then the serializer word
// register before it reaches the output. The byte serializer sets the
// rate, and the input register takes the next item while the current
// one is still being sent.
// Reset (rst_n low, asynchronous) empties the input register and serializer.
// ----------------------------------------------------------------------------
// msgpack_scalar_encoder
// Shortest MessagePack encoding of ints, length headers and float bits,
// emitted tag first then big-endian payload, one byte per output word.
// ----------------------------------------------------------------------------
module msgpack_scalar_encoder
    import msp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    msp_in_if.sink     item,
    msp_out_if.source  enc
);

    logic                     s1_valid_reg;
    logic [OP_W-1:0]          s1_op_reg;
    logic [VALUE_W-1:0]       s1_value_reg;

    logic                     ser_valid_reg;
    logic [BYTE_W+VALUE_W-1:0] word_reg;
    logic [BYTE_W+VALUE_W-1:0] word_next;
    logic [CNT_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         rem_next;

    enc_t enc_word;
    logic is_last;
    logic out_take;
    logic load_ser;
    logic in_take;

    assign is_last  = (rem_reg == '0);
    assign out_take = ser_valid_reg && enc.ready;
    assign load_ser = s1_valid_reg && (!ser_valid_reg || (out_take && is_last));
    assign in_take  = item.valid && item.ready;

    assign item.ready    = !s1_valid_reg || load_ser;
    assign enc.valid     = ser_valid_reg;
    assign enc.out_byte  = word_reg[BYTE_W+VALUE_W-1 -: BYTE_W];
    assign enc.last_byte = is_last;

    assign enc_word = msp_encode(s1_op_reg, s1_value_reg);

    always_comb
    begin
        word_next = word_reg;
        rem_next  = rem_reg;
        if (load_ser)
        begin
            word_next = {enc_word.tag, enc_word.payload};
            rem_next  = enc_word.nbytes;
        end
        else if (out_take && !is_last)
        begin
            word_next = {word_reg[VALUE_W-1:0], {BYTE_W{1'b0}}};
            rem_next  = rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (load_ser)
                s1_valid_reg <= 1'b0;

            if (load_ser)
                ser_valid_reg <= 1'b1;
            else if (out_take && is_last)
                ser_valid_reg <= 1'b0;

            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg    <= item.opcode;
            s1_value_reg <= item.value;
        end
        word_reg <= word_next;
    end

`ifndef ASSERT_OFF
    a_more_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !is_last) |=> ser_valid_reg)
        else $error("serializer dropped an item before its last byte");

    a_rem_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> ser_valid_reg)
        else $error("byte count pending with empty serializer");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !load_ser) |=> s1_valid_reg)
        else $error("input register lost an item before handoff");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && is_last && !s1_valid_reg) |=> !ser_valid_reg)
        else $error("serializer still valid after last byte with nothing queued");

    a_rem_max: assert property (@(posedge clk) disable iff (!rst_n)
        load_ser |=> (rem_reg <= CNT_W'(8)))
        else $error("payload byte count above eight");
`endif

endmodule

### verif/tb_msgpack_scalar_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_msgpack_scalar_encoder
// Drives opcode/value words into the encoder with random gaps, predicts the
// MessagePack byte stream of every accepted word, and checks each output word
// in order against it while the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_msgpack_scalar_encoder
    import msp_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] T_INT8   = 8'hD0;
    localparam logic [7:0] T_INT16  = 8'hD1;
    localparam logic [7:0] T_INT32  = 8'hD2;
    localparam logic [7:0] T_INT64  = 8'hD3;
    localparam logic [7:0] T_UINT8  = 8'hCC;
    localparam logic [7:0] T_UINT16 = 8'hCD;
    localparam logic [7:0] T_UINT32 = 8'hCE;
    localparam logic [7:0] T_UINT64 = 8'hCF;
    localparam logic [7:0] T_FIXSTR = 8'hA0;
    localparam logic [7:0] T_STR8   = 8'hD9;
    localparam logic [7:0] T_STR16  = 8'hDA;
    localparam logic [7:0] T_STR32  = 8'hDB;
    localparam logic [7:0] T_BIN8   = 8'hC4;
    localparam logic [7:0] T_BIN16  = 8'hC5;
    localparam logic [7:0] T_BIN32  = 8'hC6;
    localparam logic [7:0] T_FIXARR = 8'h90;
    localparam logic [7:0] T_ARR16  = 8'hDC;
    localparam logic [7:0] T_ARR32  = 8'hDD;
    localparam logic [7:0] T_FIXMAP = 8'h80;
    localparam logic [7:0] T_MAP16  = 8'hDE;
    localparam logic [7:0] T_MAP32  = 8'hDF;
    localparam logic [7:0] T_F32    = 8'hCA;
    localparam logic [7:0] T_F64    = 8'hCB;

    typedef struct {
        logic [7:0] out_byte;
        logic       last_byte;
    } enc_word_t;

    logic clk = 1'b0;
    logic rst_n;

    enc_word_t expected_bytes[$];
    int        err_count   = 0;
    int        cycle_count = 0;
    int        in_gap_max  = 10;
    int        out_stall_max = 10;
    logic      run_started = 1'b0;

    msp_in_if  item_ch ();
    msp_out_if enc_ch ();

    msgpack_scalar_encoder i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .enc   (enc_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // tag byte, then nbytes of payload MSB first
    task automatic push_tagged(input logic [7:0] tag, input logic [63:0] payload,
                               input int nbytes);
        enc_word_t w;
        int        k;
        w.out_byte  = tag;
        w.last_byte = (nbytes == 0);
        expected_bytes.push_back(w);
        for (k = 0; k < nbytes; k++)
        begin
            w.out_byte  = 8'(payload >> (8 * (nbytes - 1 - k)));
            w.last_byte = (k == nbytes - 1);
            expected_bytes.push_back(w);
        end
    endtask

    task automatic predict_encoding(input logic [OP_W-1:0] op, input logic [63:0] v);
        longint      s;
        logic [31:0] n;
        s = v;
        n = v[31:0];
        case (op)
            OP_SINT:
            begin
                if (s >= -32 && s <= 127)
                    push_tagged(v[7:0], 64'd0, 0);
                else if (s >= -128 && s <= 127)
                    push_tagged(T_INT8, v, 1);
                else if (s >= -32768 && s <= 32767)
                    push_tagged(T_INT16, v, 2);
                else if (s >= -64'sd2147483648 && s <= 64'sd2147483647)
                    push_tagged(T_INT32, v, 4);
                else
                    push_tagged(T_INT64, v, 8);
            end
            OP_UINT:
            begin
                if (v <= 64'd127)
                    push_tagged(v[7:0], 64'd0, 0);
                else if (v <= 64'd255)
                    push_tagged(T_UINT8, v, 1);
                else if (v <= 64'd65535)
                    push_tagged(T_UINT16, v, 2);
                else if (v <= 64'hFFFF_FFFF)
                    push_tagged(T_UINT32, v, 4);
                else
                    push_tagged(T_UINT64, v, 8);
            end
            OP_STR:
            begin
                if (n < 32)
                    push_tagged(T_FIXSTR | n[7:0], 64'd0, 0);
                else if (n <= 255)
                    push_tagged(T_STR8, 64'(n), 1);
                else if (n <= 65535)
                    push_tagged(T_STR16, 64'(n), 2);
                else
                    push_tagged(T_STR32, 64'(n), 4);
            end
            OP_BIN:
            begin
                if (n <= 255)
                    push_tagged(T_BIN8, 64'(n), 1);
                else if (n <= 65535)
                    push_tagged(T_BIN16, 64'(n), 2);
                else
                    push_tagged(T_BIN32, 64'(n), 4);
            end
            OP_ARRAY:
            begin
                if (n <= 15)
                    push_tagged(T_FIXARR | n[7:0], 64'd0, 0);
                else if (n <= 65535)
                    push_tagged(T_ARR16, 64'(n), 2);
                else
                    push_tagged(T_ARR32, 64'(n), 4);
            end
            OP_MAP:
            begin
                if (n <= 15)
                    push_tagged(T_FIXMAP | n[7:0], 64'd0, 0);
                else if (n <= 65535)
                    push_tagged(T_MAP16, 64'(n), 2);
                else
                    push_tagged(T_MAP32, 64'(n), 4);
            end
            OP_F32:
                push_tagged(T_F32, 64'(n), 4);
            default:
                push_tagged(T_F64, v, 8);
        endcase
    endtask

    // valid stays high between back-to-back words; lowered only for a gap
    task automatic send_word(input logic [OP_W-1:0] op, input logic [63:0] v);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.opcode <= op;
        item_ch.value  <= v;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predict_encoding(op, v);
    endtask

    // output side: random stall per word, then check
    initial
    begin
        int        stall;
        enc_word_t w;
        enc_ch.ready <= 1'b0;
        wait (run_started);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0)
            begin
                enc_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            enc_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(enc_ch.valid && enc_ch.ready));
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output word: out_byte %h last_byte %b",
                       enc_ch.out_byte, enc_ch.last_byte);
                err_count++;
            end
            else
            begin
                w = expected_bytes.pop_front();
                if (enc_ch.out_byte !== w.out_byte)
                begin
                    $error("out_byte: expected %h, actual %h", w.out_byte, enc_ch.out_byte);
                    err_count++;
                end
                if (enc_ch.last_byte !== w.last_byte)
                begin
                    $error("last_byte: expected %b, actual %b",
                           w.last_byte, enc_ch.last_byte);
                    err_count++;
                end
            end
        end
    end

    task automatic test_sint_bounds();
        send_word(OP_SINT, 64'd127);
        send_word(OP_SINT, -64'sd32);
        send_word(OP_SINT, -64'sd33);
        send_word(OP_SINT, -64'sd129);
        send_word(OP_SINT, 64'd32768);
        send_word(OP_SINT, -64'sd2147483649);
        send_word(OP_SINT, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_uint_bounds();
        send_word(OP_UINT, 64'd127);
        send_word(OP_UINT, 64'd128);
        send_word(OP_UINT, 64'd65535);
        send_word(OP_UINT, 64'd65536);
        send_word(OP_UINT, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // upper 32 bits of a length must not matter
    task automatic test_length_headers();
        send_word(OP_STR, 64'd31);
        send_word(OP_STR, 64'hFFFF_FFFF_0000_0020);
        send_word(OP_STR, 64'd65536);
        send_word(OP_BIN, 64'd0);
        send_word(OP_BIN, 64'd256);
        send_word(OP_BIN, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_ARRAY, 64'd15);
        send_word(OP_ARRAY, 64'h8000_0000_0000_0010);
        send_word(OP_MAP, 64'd65535);
        send_word(OP_MAP, 64'd65536);
    endtask

    task automatic test_float_bits();
        send_word(OP_F32, 64'hFFFF_FFFF_0000_0000);
        send_word(OP_F64, 64'd0);
    endtask

    function automatic logic [63:0] shaped_value();
        logic [63:0] r;
        int          k;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: ;
            1:
            begin
                k = $urandom_range(1, 64);
                r = r & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - k));
                if ($urandom_range(0, 1) == 1)
                    r = ~r;
            end
            2:
            begin
                case ($urandom_range(0, 7))
                    0: k = 4;
                    1: k = 5;
                    2: k = 7;
                    3: k = 8;
                    4: k = 15;
                    5: k = 16;
                    6: k = 31;
                    default: k = 32;
                endcase
                r = (64'd1 << k) + 64'd1 - 64'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1)
                    r = 64'd0 - r;
            end
            default: r = r & 64'hFF;
        endcase
        return r;
    endfunction

    task automatic test_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_word(OP_W'($urandom_range(0, 7)), shaped_value());
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.opcode <= '0;
        item_ch.value  <= '0;
        repeat (12) @(posedge clk);
        rst_n       <= 1'b1;
        run_started <= 1'b1;
        @(posedge clk);

        test_sint_bounds();
        test_uint_bounds();
        test_length_headers();
        test_float_bits();

        in_gap_max = 10; out_stall_max = 10;
        test_random(24);
        in_gap_max = 0;  out_stall_max = 0;
        test_random(24);
        in_gap_max = 0;  out_stall_max = 10;
        test_random(24);
        in_gap_max = 10; out_stall_max = 0;
        test_random(24);

        item_ch.valid <= 1'b0;
        wait (expected_bytes.size() == 0);
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### msgpack_scalar_encoder.f
hdl/msp_pkg.sv
hdl/msp_in_if.sv
hdl/msp_out_if.sv
hdl/msgpack_scalar_encoder.sv
verif/tb_msgpack_scalar_encoder.sv
